[hw/rtl/srfd_pkg.sv]
package srfd_pkg;

  localparam int MAX_DATA_BYTES_DEF = 10;
  localparam int POS_W = 5;
  localparam int CRC_W = 13;

  localparam logic [7:0] KIND_LEVELS = 8'h50;
  localparam logic [7:0] KIND_AVG    = 8'h51;
  localparam logic [7:0] KIND_TEMPS  = 8'h52;

  localparam logic [CRC_W-1:0] CRC_POLY = 13'h180d;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_CRC = 2'd1,
    STAT_LEN = 2'd2
  } status_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CRC_W-1:0] crc_t;

endpackage

[hw/rtl/srfd_ifs.sv]
interface srfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source(output valid, output rx_byte, output frame_start, input ready);
  modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

interface srfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] sensor_id;
  logic [7:0]  data_kind;
  logic [2:0]  value_count;
  logic [23:0] value_a;
  logic [23:0] value_b;
  logic [15:0] value_c;
  logic [15:0] value_d;
  logic [15:0] value_e;

  modport source(
    output valid, output status, output sensor_id, output data_kind, output value_count,
    output value_a, output value_b, output value_c, output value_d, output value_e,
    input ready
  );
  modport sink(
    input valid, input status, input sensor_id, input data_kind, input value_count,
    input value_a, input value_b, input value_c, input value_d, input value_e,
    output ready
  );
endinterface

[hw/rtl/srfd_crc.sv]
module srfd_crc (
  input  srfd_pkg::crc_t crc_in,
  input  logic [7:0]     data_byte,
  input  logic           feed_en,
  input  logic [15:0]    rx_crc,
  output srfd_pkg::crc_t crc_nxt,
  output logic           crc_match
);
  import srfd_pkg::*;

  function automatic crc_t crc_step(input crc_t c, input logic data_bit);
    crc_t t;
    t = c;
    t[0] = t[0] | data_bit;
    if (t[CRC_W-1]) begin
      t = t ^ CRC_POLY;
    end
    return {t[CRC_W-2:0], 1'b0};
  endfunction

  function automatic crc_t crc_feed(input crc_t c, input logic [7:0] b);
    crc_t t;
    t = c;
    for (int i = 7; i >= 0; i--) begin
      t = crc_step(t, b[i]);
    end
    return t;
  endfunction

  function automatic logic [11:0] crc_finish(input crc_t c);
    crc_t t;
    t = c;
    for (int i = 0; i < 12; i++) begin
      t = crc_step(t, 1'b0);
    end
    return t[12:1];
  endfunction

  logic [11:0] crc_final;

  assign crc_nxt   = feed_en ? crc_feed(crc_in, data_byte) : crc_in;
  assign crc_final = crc_finish(crc_nxt);
  assign crc_match = ({4'd0, crc_final} == rx_crc);

endmodule

[hw/rtl/sensor_response_frame_decoder.sv]
// Decodes one sensor response frame per pass, one byte per transfer on in_ch, with no
// cycle lost between bytes: head, length, three ID bytes, type, data, CRC high and
// low, tail. The 12-bit CRC is folded byte by byte and checked at the tail. The single
// result per frame is loaded into the output register at the tail byte's transfer and
// is offered on out_ch from the next cycle. Input bytes are taken every cycle; the only
// stall is a byte arriving at the tail position, tail or new head, while the previous
// result still sits unclaimed in the output register.
module sensor_response_frame_decoder #(
  parameter int MAX_DATA_BYTES = srfd_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  srfd_in_if.sink           in_ch,
  srfd_out_if.source        out_ch
);
  import srfd_pkg::*;

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_DATA_BYTES);

  pos_t        pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  crc_t        crc_r, crc_nxt, crc_fed;
  logic [23:0] id_r, id_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  store_r [MAX_DATA_BYTES];
  logic [7:0]  dat [10];

  logic        in_xfer, at_tail, emit, feed_en, crc_match, store_we;
  pos_t        dcnt, tail_pos, pos_m2, pos_m6;
  status_t     stat;
  logic [2:0]  cnt;
  logic [23:0] va, vb;
  logic [15:0] vc, vd, ve;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [23:0] id_out_r, va_r, vb_r;
  logic [7:0]  kind_out_r;
  logic [2:0]  cnt_r;
  logic [15:0] vc_r, vd_r, ve_r;

  function automatic pos_t data_count(input logic [7:0] kind, input logic [7:0] len);
    logic [7:0] n;
    n = len - 8'd4;
    case (kind)
      KIND_LEVELS: return POS_W'(6);
      KIND_AVG:    return POS_W'(2);
      KIND_TEMPS:  return POS_W'(10);
      default: begin
        if (len < 8'd4) begin
          return '0;
        end else if (n > 8'(MAX_DATA_BYTES)) begin
          return MAX_P;
        end else begin
          return n[POS_W-1:0];
        end
      end
    endcase
  endfunction

  assign dcnt     = data_count(kind_r, len_r);
  assign tail_pos = POS_W'(8) + dcnt;
  assign pos_m2   = pos_r - POS_W'(2);
  assign pos_m6   = pos_r - POS_W'(6);
  assign at_tail  = (pos_r >= POS_W'(6)) && (pos_r == tail_pos);
  assign feed_en  = (pos_r >= POS_W'(2)) && ({3'd0, pos_m2} < len_r);

  assign in_ch.ready = !out_valid_r || out_ch.ready || !at_tail;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign emit        = in_xfer && !in_ch.frame_start && at_tail;

  srfd_crc u_crc (
    .crc_in    (crc_r),
    .data_byte (in_ch.rx_byte),
    .feed_en   (feed_en),
    .rx_crc    (rcrc_r),
    .crc_nxt   (crc_fed),
    .crc_match (crc_match)
  );

  // frame sequencing
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    id_nxt   = id_r;
    kind_nxt = kind_r;
    rcrc_nxt = rcrc_r;
    store_we = 1'b0;
    if (in_xfer) begin
      if (in_ch.frame_start) begin
        pos_nxt  = POS_W'(1);
        len_nxt  = '0;
        crc_nxt  = '0;
        id_nxt   = '0;
        kind_nxt = '0;
        rcrc_nxt = '0;
      end else if (pos_r == POS_W'(1)) begin
        len_nxt = in_ch.rx_byte;
        pos_nxt = POS_W'(2);
      end else if (pos_r != '0) begin
        crc_nxt = crc_fed;
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r <= POS_W'(4)) begin
          id_nxt = {id_r[15:0], in_ch.rx_byte};
        end else if (pos_r == POS_W'(5)) begin
          kind_nxt = in_ch.rx_byte;
        end else if (pos_r < POS_W'(6) + dcnt) begin
          store_we = (pos_m6 < MAX_P);
        end else if (pos_r == POS_W'(6) + dcnt) begin
          rcrc_nxt = {in_ch.rx_byte, 8'd0};
        end else if (pos_r == POS_W'(7) + dcnt) begin
          rcrc_nxt = {rcrc_r[15:8], in_ch.rx_byte};
        end else begin
          pos_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
    len_r  <= len_nxt;
    crc_r  <= crc_nxt;
    id_r   <= id_nxt;
    kind_r <= kind_nxt;
    rcrc_r <= rcrc_nxt;
  end

  for (genvar i = 0; i < MAX_DATA_BYTES; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (store_we && (pos_m6[IDX_W-1:0] == IDX_W'(i))) begin
        store_r[i] <= in_ch.rx_byte;
      end
    end
  end

  for (genvar i = 0; i < 10; i++) begin : g_dat
    if (i < MAX_DATA_BYTES) begin : g_in
      assign dat[i] = store_r[i];
    end else begin : g_out
      assign dat[i] = 8'd0;
    end
  end

  // result
  always_comb begin
    if (len_r > (8'(dcnt) + 8'd7)) begin
      stat = STAT_LEN;
    end else if (!crc_match) begin
      stat = STAT_CRC;
    end else begin
      stat = STAT_OK;
    end
    cnt = '0;
    va  = '0;
    vb  = '0;
    vc  = '0;
    vd  = '0;
    ve  = '0;
    if (stat == STAT_OK) begin
      case (kind_r)
        KIND_LEVELS: begin
          cnt = 3'd2;
          va  = {dat[0], dat[1], dat[2]};
          vb  = {dat[3], dat[4], dat[5]};
        end
        KIND_AVG: begin
          cnt = 3'd1;
          va  = {8'd0, dat[0], dat[1]};
        end
        KIND_TEMPS: begin
          cnt = 3'd5;
          va  = {8'd0, dat[0], dat[1]};
          vb  = {8'd0, dat[2], dat[3]};
          vc  = {dat[4], dat[5]};
          vd  = {dat[6], dat[7]};
          ve  = {dat[8], dat[9]};
        end
        default: begin
          cnt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      status_r   <= stat;
      id_out_r   <= id_r;
      kind_out_r <= kind_r;
      cnt_r      <= cnt;
      va_r       <= va;
      vb_r       <= vb;
      vc_r       <= vc;
      vd_r       <= vd;
      ve_r       <= ve;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.sensor_id   = id_out_r;
  assign out_ch.data_kind   = kind_out_r;
  assign out_ch.value_count = cnt_r;
  assign out_ch.value_a     = va_r;
  assign out_ch.value_b     = vb_r;
  assign out_ch.value_c     = vc_r;
  assign out_ch.value_d     = vd_r;
  assign out_ch.value_e     = ve_r;

endmodule

[hw/rtl/srfd_checker.sv]
module srfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  data_kind,
  input logic [2:0]  value_count,
  input logic [23:0] value_a,
  input logic [23:0] value_b,
  input logic [15:0] value_c,
  input logic [15:0] value_d,
  input logic [15:0] value_e
);
  import srfd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_a))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != STAT_OK) |->
      value_count == 3'd0 && value_a == '0 && value_b == '0 &&
      value_c == '0 && value_d == '0 && value_e == '0)
    else $error("failed frame carries values");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_OK) |->
      ((data_kind == KIND_LEVELS) && value_count == 3'd2) ||
      ((data_kind == KIND_AVG) && value_count == 3'd1) ||
      ((data_kind == KIND_TEMPS) && value_count == 3'd5) ||
      ((data_kind != KIND_LEVELS) && (data_kind != KIND_AVG) &&
       (data_kind != KIND_TEMPS) && value_count == 3'd0))
    else $error("value count does not match type");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && value_count < 3'd5 |->
      value_c == '0 && value_d == '0 && value_e == '0 &&
      (value_count >= 3'd2 || value_b == '0) &&
      (value_count >= 3'd2 || value_a[23:16] == '0))
    else $error("value beyond count is not zero");

endmodule

bind sensor_response_frame_decoder srfd_checker u_srfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .data_kind   (out_ch.data_kind),
  .value_count (out_ch.value_count),
  .value_a     (out_ch.value_a),
  .value_b     (out_ch.value_b),
  .value_c     (out_ch.value_c),
  .value_d     (out_ch.value_d),
  .value_e     (out_ch.value_e)
);
